// File: rtl/core/rrts_pkg.sv
// Shared constants, codes and types of the round-robin thread scheduler.
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = 4;
    localparam int QIDX_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int PRIO_W      = 8;
    localparam int PID_W       = 16;
    localparam int ST_W        = 3;
    localparam int ACT_W       = 2;
    localparam int KIND_W      = 2;
    localparam int ERR_W       = 2;

    localparam logic [PRIO_W-1:0] MAIN_PRIO = PRIO_W'(31);
    localparam logic [PID_W-1:0]  MAIN_PID  = PID_W'(1);

    // thread status codes
    localparam logic [ST_W-1:0] ST_UNUSED  = 3'd0;
    localparam logic [ST_W-1:0] ST_RUNNING = 3'd1;
    localparam logic [ST_W-1:0] ST_READY   = 3'd2;
    localparam logic [ST_W-1:0] ST_BLOCKED = 3'd3;
    localparam logic [ST_W-1:0] ST_WAITING = 3'd4;
    localparam logic [ST_W-1:0] ST_HANGING = 3'd5;

    // actions
    localparam logic [ACT_W-1:0] ACT_CREATE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SCHED   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_BLOCK   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_UNBLOCK = 2'd3;

    // block kinds
    localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WAITING = 2'd1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY       = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOT_BLOCKED = 2'd2;
    localparam logic [ERR_W-1:0] ERR_IN_USE      = 2'd3;

    // one ready-queue entry: slot and its priority (= slice length)
    typedef struct packed {
        logic [SLOT_W-1:0] id;
        logic [PRIO_W-1:0] prio;
    } qentry_t;

    // broadcast control of the queue cell chain
    typedef struct packed {
        logic              shl;   // pop head: every cell takes its right neighbor
        logic              shr;   // push front: every cell takes its left neighbor
        logic              wr;    // write data at pos (after any shift)
        logic [QIDX_W-1:0] pos;
        qentry_t           data;
    } qctl_t;

endpackage

// File: rtl/core/rrts_qcell.sv
// One cell of the ready-queue chain: holds one entry, moves it left or right.
module rrts_qcell (
    input  logic                       clk,
    input  rrts_pkg::qctl_t            ctl,
    input  logic [rrts_pkg::QIDX_W-1:0] cell_idx,
    input  rrts_pkg::qentry_t          prev_entry,
    input  rrts_pkg::qentry_t          next_entry,
    output rrts_pkg::qentry_t          entry
);
    import rrts_pkg::*;

    qentry_t entry_reg;
    qentry_t entry_next;

    always_comb
    begin
        if (ctl.wr && (ctl.pos == cell_idx))
        begin
            entry_next = ctl.data;
        end
        else if (ctl.shl)
        begin
            entry_next = next_entry;
        end
        else if (ctl.shr)
        begin
            entry_next = prev_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/core/rrts_ready_queue.sv
// Ready deque built as a chain of shifting cells; head sits in cell 0.
module rrts_ready_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rrts_pkg::qctl_t             ctl,
    output rrts_pkg::qentry_t           head,
    output logic [rrts_pkg::CNT_W-1:0]  count
);
    import rrts_pkg::*;

    qentry_t           cells [MAX_THREADS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    for (genvar i = 0; i < MAX_THREADS; i++)
    begin : g_cell
        qentry_t prev_e;
        qentry_t next_e;

        if (i == 0)
        begin : g_first
            assign prev_e = ctl.data;   // push front enters here
        end
        else
        begin : g_mid
            assign prev_e = cells[i-1];
        end

        if (i == MAX_THREADS - 1)
        begin : g_last
            assign next_e = ctl.data;   // beyond the live window, don't care
        end
        else
        begin : g_inner
            assign next_e = cells[i+1];
        end

        rrts_qcell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .cell_idx   (QIDX_W'(i)),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (cells[i])
        );
    end

    // pop+append keeps the count
    always_comb
    begin
        count_next = count_reg;
        if (ctl.shr || (ctl.wr && !ctl.shl))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.shl && !ctl.wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = cells[0];
    assign count = count_reg;

endmodule

// File: rtl/core/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler with ready deque.
// Latency: the result strobe (done) is high in the cycle right after start.
// Throughput: one item per cycle; busy never rises and all state updates at
// the accepting edge, so back-to-back items see each other's effects.
// Reset: slot 0 (main thread) running with priority and ticks 31 and pid 1,
// all other slots unused, ready queue empty. No clearing pass is needed.
module round_robin_thread_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rrts_pkg::ACT_W-1:0]    action,
    input  logic [rrts_pkg::SLOT_W-1:0]   thread_id,
    input  logic [rrts_pkg::PRIO_W-1:0]   priority_req,
    input  logic [rrts_pkg::KIND_W-1:0]   block_kind,
    output logic                          done,
    output logic [rrts_pkg::SLOT_W-1:0]   running_id,
    output logic                          switched,
    output logic [rrts_pkg::PID_W-1:0]    new_pid,
    output logic [rrts_pkg::PRIO_W-1:0]   running_ticks,
    output logic [rrts_pkg::ERR_W-1:0]    error
);
    import rrts_pkg::*;

    // ------------------------------------------------------------------
    // State
    // Ticks always equal priority (set together on create, reloaded from
    // priority on schedule), so one priority value serves both.
    // The running thread's priority is kept in run_prio_reg; queued threads
    // carry theirs inside the queue entry. The per-slot priority table is
    // only read back when a parked thread is unblocked.
    // ------------------------------------------------------------------
    logic [ST_W-1:0]   status_reg   [MAX_THREADS];
    logic [PRIO_W-1:0] prio_tab_reg [MAX_THREADS];
    logic [SLOT_W-1:0] cur_reg,      cur_next;
    logic [PRIO_W-1:0] run_prio_reg, run_prio_next;
    logic [PID_W-1:0]  pid_reg,      pid_next;

    // result registers
    logic              done_reg;
    logic              switched_reg, switched_next;
    logic [PID_W-1:0]  new_pid_reg,  new_pid_next;
    logic [ERR_W-1:0]  error_reg,    error_next;

    // ready queue
    qctl_t             qctl;
    qentry_t           q_head;
    logic [CNT_W-1:0]  q_count;
    logic              q_full;
    logic              q_empty;

    // slot table write ports: A is the ordinary write, B marks the new
    // running thread and wins when both hit the same slot
    logic              wa_en;
    logic [SLOT_W-1:0] wa_slot;
    logic [ST_W-1:0]   wa_st;
    logic              wb_en;
    logic              prio_wr;

    logic              accept;
    logic [ST_W-1:0]   st_sel;
    logic [PRIO_W-1:0] prio_sel;
    logic              parked;
    logic [ST_W-1:0]   kind_st;

    assign busy    = 1'b0;
    assign accept  = start && !busy;

    assign q_full  = (q_count == CNT_W'(MAX_THREADS));
    assign q_empty = (q_count == '0);

    assign st_sel   = status_reg[thread_id];
    assign prio_sel = prio_tab_reg[thread_id];
    assign parked   = (st_sel == ST_BLOCKED) || (st_sel == ST_WAITING) ||
                      (st_sel == ST_HANGING);

    // kind 3 means nothing and parks as hanging
    always_comb
    begin
        case (block_kind)
            KIND_BLOCKED: kind_st = ST_BLOCKED;
            KIND_WAITING: kind_st = ST_WAITING;
            default:      kind_st = ST_HANGING;
        endcase
    end

    rrts_ready_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl),
        .head  (q_head),
        .count (q_count)
    );

    // ------------------------------------------------------------------
    // Item decode
    // ------------------------------------------------------------------
    always_comb
    begin
        qctl          = '0;
        cur_next      = cur_reg;
        run_prio_next = run_prio_reg;
        pid_next      = pid_reg;
        switched_next = 1'b0;
        new_pid_next  = '0;
        error_next    = ERR_OK;
        wa_en         = 1'b0;
        wa_slot       = thread_id;
        wa_st         = ST_READY;
        wb_en         = 1'b0;
        prio_wr       = 1'b0;

        if (accept)
        begin
            unique case (action)
                ACT_CREATE:
                begin
                    if (st_sel != ST_UNUSED)
                    begin
                        error_next = ERR_IN_USE;
                    end
                    else if (q_full)
                    begin
                        error_next = ERR_EMPTY;
                    end
                    else
                    begin
                        pid_next      = pid_reg + 1'b1;
                        new_pid_next  = pid_reg + 1'b1;
                        wa_en         = 1'b1;
                        prio_wr       = 1'b1;
                        qctl.wr       = 1'b1;
                        qctl.pos      = q_count[QIDX_W-1:0];
                        qctl.data.id  = thread_id;
                        qctl.data.prio = priority_req;
                    end
                end

                ACT_SCHED:
                begin
                    // with an empty queue the running thread requeues and is
                    // popped right back: same thread, ticks reloaded (no change)
                    switched_next = 1'b1;
                    if (!q_empty)
                    begin
                        qctl.shl = 1'b1;
                        if (!q_full)
                        begin
                            qctl.wr        = 1'b1;
                            qctl.pos       = q_count[QIDX_W-1:0] - 1'b1;
                            qctl.data.id   = cur_reg;
                            qctl.data.prio = run_prio_reg;
                            wa_en          = 1'b1;
                            wa_slot        = cur_reg;
                        end
                        wb_en         = 1'b1;
                        cur_next      = q_head.id;
                        run_prio_next = q_head.prio;
                    end
                end

                ACT_BLOCK:
                begin
                    if (q_empty)
                    begin
                        error_next = ERR_EMPTY;
                    end
                    else
                    begin
                        switched_next = 1'b1;
                        wa_en         = 1'b1;
                        wa_slot       = cur_reg;
                        wa_st         = kind_st;
                        qctl.shl      = 1'b1;
                        wb_en         = 1'b1;
                        cur_next      = q_head.id;
                        run_prio_next = q_head.prio;
                    end
                end

                ACT_UNBLOCK:
                begin
                    if (!parked)
                    begin
                        error_next = ERR_NOT_BLOCKED;
                    end
                    else if (q_full)
                    begin
                        error_next = ERR_EMPTY;
                    end
                    else
                    begin
                        qctl.shr       = 1'b1;
                        qctl.data.id   = thread_id;
                        qctl.data.prio = prio_sel;
                        wa_en          = 1'b1;
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Slot table
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                status_reg[i]   <= (i == 0) ? ST_RUNNING : ST_UNUSED;
                prio_tab_reg[i] <= (i == 0) ? MAIN_PRIO : '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                if (wb_en && (q_head.id == SLOT_W'(i)))
                begin
                    status_reg[i] <= ST_RUNNING;
                end
                else if (wa_en && (wa_slot == SLOT_W'(i)))
                begin
                    status_reg[i] <= wa_st;
                end
                if (prio_wr && (thread_id == SLOT_W'(i)))
                begin
                    prio_tab_reg[i] <= priority_req;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Running thread, pid counter, result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            run_prio_reg <= MAIN_PRIO;
            pid_reg      <= MAIN_PID;
            done_reg     <= 1'b0;
        end
        else
        begin
            cur_reg      <= cur_next;
            run_prio_reg <= run_prio_next;
            pid_reg      <= pid_next;
            done_reg     <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            switched_reg <= switched_next;
            new_pid_reg  <= new_pid_next;
            error_reg    <= error_next;
        end
    end

    // running thread state only moves on an accepted item, so the live
    // registers double as the result fields
    assign done          = done_reg;
    assign running_id    = cur_reg;
    assign running_ticks = run_prio_reg;
    assign switched      = switched_reg;
    assign new_pid       = new_pid_reg;
    assign error         = error_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("result strobe missing after accepted item");

    a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg[cur_reg] == ST_RUNNING)
        else $error("current thread not marked running");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count < CNT_W'(MAX_THREADS))
        else $error("ready queue holds more than the non-running slots");

    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && switched |-> error == ERR_OK && new_pid == '0)
        else $error("switch reported with error or pid");

    a_pid_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && (new_pid != '0) |-> new_pid == pid_reg)
        else $error("returned pid differs from pid counter");

endmodule

// File: dv/sched_sb_pkg.sv
// Scoreboard class for the thread scheduler: state predictor and result checker.
`timescale 1ns / 100ps

package sched_sb_pkg;

    import rrts_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] running_id;
        logic              switched;
        logic [PID_W-1:0]  new_pid;
        logic [PRIO_W-1:0] running_ticks;
        logic [ERR_W-1:0]  error;
    } sched_result_t;

    class sched_scoreboard;

        // predicted scheduler state
        logic [ST_W-1:0]   slot_status [MAX_THREADS];
        logic [PRIO_W-1:0] slot_prio   [MAX_THREADS];
        logic [PRIO_W-1:0] slot_ticks  [MAX_THREADS];
        logic [SLOT_W-1:0] ready_ring  [MAX_THREADS];
        logic [QIDX_W-1:0] ring_head;
        logic [CNT_W-1:0]  ring_count;
        logic [SLOT_W-1:0] cur_slot;
        logic [PID_W-1:0]  last_pid;

        sched_result_t expected_results[$];

        int n_items;
        int n_checked;
        int n_mismatch;
        int n_switches;
        int n_by_action[4];
        int n_by_error[4];

        function new();
            for (int s = 0; s < MAX_THREADS; s++) begin
                slot_status[s] = ST_UNUSED;
                slot_prio[s]   = '0;
                slot_ticks[s]  = '0;
                ready_ring[s]  = '0;
            end
            slot_status[0] = ST_RUNNING;
            slot_prio[0]   = MAIN_PRIO;
            slot_ticks[0]  = MAIN_PRIO;
            ring_head      = '0;
            ring_count     = '0;
            cur_slot       = '0;
            last_pid       = MAIN_PID;
        endfunction

        function bit is_parked(logic [SLOT_W-1:0] slot);
            return slot_status[slot] inside {ST_BLOCKED, ST_WAITING, ST_HANGING};
        endfunction

        // ring depth is a power of two, so index arithmetic wraps on its own
        function void append_tail(logic [SLOT_W-1:0] slot);
            ready_ring[QIDX_W'(ring_head + ring_count)] = slot;
            ring_count++;
        endfunction

        function void run_head();
            cur_slot = ready_ring[ring_head];
            slot_status[cur_slot] = ST_RUNNING;
            ring_head++;
            ring_count--;
        endfunction

        // random slot that is unused (parked == 0) or parked (parked == 1), -1 if none
        function int pick_slot(bit parked);
            int cands[$];
            for (int s = 0; s < MAX_THREADS; s++)
                if (parked ? is_parked(SLOT_W'(s)) : (slot_status[s] == ST_UNUSED))
                    cands.push_back(s);
            if (cands.size() == 0)
                return -1;
            return cands[$urandom_range(0, cands.size() - 1)];
        endfunction

        function void note_item(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] slot,
                                logic [PRIO_W-1:0] prio, logic [KIND_W-1:0] kind);
            sched_result_t r;
            r = '0;
            case (act)
                ACT_CREATE: begin
                    if (slot_status[slot] != ST_UNUSED)
                        r.error = ERR_IN_USE;
                    else if (ring_count >= MAX_THREADS)
                        r.error = ERR_EMPTY;
                    else begin
                        last_pid++;
                        r.new_pid = last_pid;
                        slot_status[slot] = ST_READY;
                        slot_prio[slot]   = prio;
                        slot_ticks[slot]  = prio;
                        append_tail(slot);
                    end
                end
                ACT_SCHED: begin
                    if (slot_status[cur_slot] == ST_RUNNING && ring_count < MAX_THREADS) begin
                        append_tail(cur_slot);
                        slot_ticks[cur_slot]  = slot_prio[cur_slot];
                        slot_status[cur_slot] = ST_READY;
                    end
                    if (ring_count == 0)
                        r.error = ERR_EMPTY;
                    else begin
                        run_head();
                        r.switched = 1'b1;
                    end
                end
                ACT_BLOCK: begin
                    if (ring_count == 0)
                        r.error = ERR_EMPTY;
                    else begin
                        case (kind)
                            KIND_BLOCKED: slot_status[cur_slot] = ST_BLOCKED;
                            KIND_WAITING: slot_status[cur_slot] = ST_WAITING;
                            default:      slot_status[cur_slot] = ST_HANGING;
                        endcase
                        run_head();
                        r.switched = 1'b1;
                    end
                end
                default: begin
                    if (!is_parked(slot))
                        r.error = ERR_NOT_BLOCKED;
                    else if (ring_count >= MAX_THREADS)
                        r.error = ERR_EMPTY;
                    else begin
                        ring_head--;
                        ready_ring[ring_head] = slot;
                        ring_count++;
                        slot_status[slot] = ST_READY;
                    end
                end
            endcase
            r.running_id    = cur_slot;
            r.running_ticks = slot_ticks[cur_slot];
            expected_results.push_back(r);
            n_items++;
            n_by_action[act]++;
            n_by_error[r.error]++;
            if (r.switched)
                n_switches++;
        endfunction

        function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                             $time, n_checked, fname, want, got);
            end
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] result strobe with no item outstanding", $time);
                return;
            end
            want = expected_results.pop_front();
            compare_field("running_id",    want.running_id,    got.running_id);
            compare_field("switched",      want.switched,      got.switched);
            compare_field("new_pid",       want.new_pid,       got.new_pid);
            compare_field("running_ticks", want.running_ticks, got.running_ticks);
            compare_field("error",         want.error,         got.error);
            n_checked++;
        endfunction

    endclass

endpackage

// File: dv/tb.sv
// Self-checking testbench for the round-robin thread scheduler.
`timescale 1ns / 100ps

module tb;

    import rrts_pkg::*;
    import sched_sb_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 650;
    // idle gaps between items are bounded in send_item and a result follows every
    // accepted item, so this is many times the slowest legal stretch without progress
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;

    // the package names only two block kinds; the other two codes live here
    localparam logic [KIND_W-1:0] KIND_HANGING  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic [ACT_W-1:0]    action       = '0;
    logic [SLOT_W-1:0]   thread_id    = '0;
    logic [PRIO_W-1:0]   priority_req = '0;
    logic [KIND_W-1:0]   block_kind   = '0;
    logic                busy;
    logic                done;
    logic [SLOT_W-1:0]   running_id;
    logic                switched;
    logic [PID_W-1:0]    new_pid;
    logic [PRIO_W-1:0]   running_ticks;
    logic [ERR_W-1:0]    error;

    sched_scoreboard sb;
    bit              idle_on = 1'b1;   // random gaps between items when set
    int              stall_cycles = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    round_robin_thread_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .thread_id    (thread_id),
        .priority_req (priority_req),
        .block_kind   (block_kind),
        .done         (done),
        .running_id   (running_id),
        .switched     (switched),
        .new_pid      (new_pid),
        .running_ticks(running_ticks),
        .error        (error)
    );

    // Issue one item. Fields go out with nonblocking assignments at the edge we
    // are sitting on; the item is taken at the first later edge where busy is
    // low. The prediction is made right there, in this process, so the next
    // stimulus choice always sees the updated predicted state.
    // start is dropped only when a gap follows, so back-to-back items never
    // see start lowered and raised in the same time step.
    task automatic send_item(input logic [ACT_W-1:0]  act,
                             input logic [SLOT_W-1:0] slot,
                             input logic [PRIO_W-1:0] prio,
                             input logic [KIND_W-1:0] kind);
        int roll;
        int gap;
        start        <= 1'b1;
        action       <= act;
        thread_id    <= slot;
        priority_req <= prio;
        block_kind   <= kind;
        do @(posedge clk); while (busy);
        sb.note_item(act, slot, prio, kind);
        // mostly no gap, often a short one, now and then a long one
        gap = 0;
        if (idle_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 92)
                gap = $urandom_range(8, 40);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Result monitor: done is a one-cycle strobe and cannot be held off, so
    // every edge with done high carries a result. Outputs are read at the edge
    // before the block's own updates land.
    always @(posedge clk) begin : result_mon
        sched_result_t got;
        if (rst_n && done) begin
            got = {running_id, switched, new_pid, running_ticks, error};
            sb.check_result(got);
        end
    end

    // Watchdog: counts edges at which neither an item nor a result moves.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, stall_cycles);
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        int                pick;
        int                cand;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic [KIND_W-1:0] kind;

        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // schedule with nothing queued: main is requeued and picked again
        send_item(ACT_SCHED, 4'd0, 8'd0, KIND_BLOCKED);
        // block with empty ready queue is refused
        send_item(ACT_BLOCK, 4'd0, 8'd0, KIND_BLOCKED);
        // unblock of an unused slot and of the running slot
        send_item(ACT_UNBLOCK, 4'd5, 8'd0, KIND_BLOCKED);
        send_item(ACT_UNBLOCK, 4'd0, 8'd0, KIND_BLOCKED);
        // create on the main slot: already in use
        send_item(ACT_CREATE, 4'd0, 8'hFF, KIND_BLOCKED);
        // top slot with largest slice, slot 1 with zero slice, then a repeat
        send_item(ACT_CREATE, 4'd15, 8'hFF, KIND_RESERVED);
        send_item(ACT_CREATE, 4'd1, 8'h00, KIND_BLOCKED);
        send_item(ACT_CREATE, 4'd15, 8'h00, KIND_BLOCKED);
        // run slot 15, then park threads with every block kind
        send_item(ACT_SCHED, 4'd0, 8'd0, KIND_BLOCKED);
        send_item(ACT_BLOCK, 4'd0, 8'd0, KIND_BLOCKED);
        send_item(ACT_BLOCK, 4'd0, 8'd0, KIND_WAITING);
        send_item(ACT_CREATE, 4'd2, 8'hAA, KIND_BLOCKED);
        send_item(ACT_BLOCK, 4'd0, 8'd0, KIND_HANGING);
        send_item(ACT_CREATE, 4'd3, 8'h55, KIND_BLOCKED);
        // undefined kind code acts as hanging
        send_item(ACT_BLOCK, 4'd0, 8'd0, KIND_RESERVED);
        // everyone else is parked now: refused
        send_item(ACT_BLOCK, 4'd0, 8'd0, KIND_WAITING);
        // wake them to the queue head, in reverse order of wanted runs
        send_item(ACT_UNBLOCK, 4'd15, 8'd0, KIND_BLOCKED);
        send_item(ACT_UNBLOCK, 4'd1, 8'd0, KIND_BLOCKED);
        send_item(ACT_UNBLOCK, 4'd0, 8'd0, KIND_BLOCKED);
        send_item(ACT_UNBLOCK, 4'd2, 8'd0, KIND_BLOCKED);
        // already ready: not parked
        send_item(ACT_UNBLOCK, 4'd15, 8'd0, KIND_BLOCKED);
        send_item(ACT_SCHED, 4'd0, 8'd0, KIND_BLOCKED);
        send_item(ACT_SCHED, 4'd0, 8'd0, KIND_BLOCKED);

        // ---- random part ----
        // Creates mostly target a free slot and unblocks mostly a parked one,
        // so the thread pool fills and threads cycle through park and wake.
        // Unused fields carry random values as noise.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            slot = SLOT_W'($urandom_range(0, MAX_THREADS - 1));
            prio = PRIO_W'($urandom);
            kind = KIND_W'($urandom);
            if (pick < 15) begin
                cand = sb.pick_slot(1'b0);
                if (cand >= 0 && $urandom_range(0, 3) != 0)
                    slot = SLOT_W'(cand);
                send_item(ACT_CREATE, slot, prio, kind);
            end
            else if (pick < 45)
                send_item(ACT_SCHED, slot, prio, kind);
            else if (pick < 70)
                send_item(ACT_BLOCK, slot, prio, kind);
            else begin
                cand = sb.pick_slot(1'b1);
                if (cand >= 0 && $urandom_range(0, 4) != 0)
                    slot = SLOT_W'(cand);
                send_item(ACT_UNBLOCK, slot, prio, kind);
            end
        end
        start <= 1'b0;

        // drain: the watchdog bounds this wait
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d items (%0d create, %0d schedule, %0d block, %0d unblock), %0d results checked.",
                 sb.n_items, sb.n_by_action[ACT_CREATE], sb.n_by_action[ACT_SCHED],
                 sb.n_by_action[ACT_BLOCK], sb.n_by_action[ACT_UNBLOCK], sb.n_checked);
        $display("Switches %0d; refusals: empty queue %0d, not parked %0d, slot in use %0d.",
                 sb.n_switches, sb.n_by_error[ERR_EMPTY], sb.n_by_error[ERR_NOT_BLOCKED],
                 sb.n_by_error[ERR_IN_USE]);
        if (sb.n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: round_robin_thread_scheduler.f
rtl/core/rrts_pkg.sv
rtl/core/rrts_qcell.sv
rtl/core/rrts_ready_queue.sv
rtl/core/round_robin_thread_scheduler.sv
dv/sched_sb_pkg.sv
dv/tb.sv
